>>> hdl/pmid_pkg.sv
package pmid_pkg;

    // spatial dimensions and periodic images per query
    localparam int NUM_DIMS = 3;
    localparam int NUM_IMG  = 27;
    localparam int NUM_REGS = 3;

    // result field and its padded stream width
    localparam int OUT_BITS       = 49;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 64;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_VEC_A = 2'd0;
    localparam t_reg_idx REG_VEC_B = 2'd1;
    localparam t_reg_idx REG_VEC_C = 2'd2;

endpackage

>>> hdl/pmid_diff.sv
module pmid_diff import pmid_pkg::*; #(
    parameter int COORD_BITS = 21,
    localparam int DIFF_BITS = COORD_BITS + 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_point [NUM_DIMS],
    input  logic signed [COORD_BITS-1:0] i_atom  [NUM_DIMS],
    input  logic signed [COORD_BITS-1:0] i_vec_a [NUM_DIMS],
    input  logic signed [COORD_BITS-1:0] i_vec_b [NUM_DIMS],
    input  logic signed [COORD_BITS-1:0] i_vec_c [NUM_DIMS],
    output logic                         o_valid,
    output logic signed [DIFF_BITS-1:0]  o_diff  [NUM_IMG][NUM_DIMS]
);

    // coefficient code 0 is -1, 1 is 0, 2 is +1; returns x - coef * v
    function automatic logic signed [DIFF_BITS-1:0] f_sub_scaled(
        input logic signed [DIFF_BITS-1:0]  x,
        input logic signed [COORD_BITS-1:0] v,
        input logic [1:0]                   sel
    );
        logic signed [DIFF_BITS-1:0] ve;
        ve = DIFF_BITS'(v);
        case (sel)
            2'd0:    return x + ve;
            2'd2:    return x - ve;
            default: return x;
        endcase
    endfunction

    logic                          r_v1, r_v2, r_v3;
    logic signed [COORD_BITS:0]    r_d0 [NUM_DIMS];
    logic signed [COORD_BITS:0]    n_d0 [NUM_DIMS];
    logic signed [DIFF_BITS-1:0]   r_t  [NUM_DIMS][3][3];
    logic signed [DIFF_BITS-1:0]   n_t  [NUM_DIMS][3][3];
    logic signed [DIFF_BITS-1:0]   r_diff [NUM_IMG][NUM_DIMS];
    logic signed [DIFF_BITS-1:0]   n_diff [NUM_IMG][NUM_DIMS];

    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            n_d0[d] = (COORD_BITS + 1)'(i_point[d]) - (COORD_BITS + 1)'(i_atom[d]);
        end
    end

    // partial offsets over the b and c lattice vectors
    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    n_t[d][j][k] = f_sub_scaled(
                        f_sub_scaled(DIFF_BITS'(r_d0[d]), i_vec_b[d], 2'(j)),
                        i_vec_c[d], 2'(k));
                end
            end
        end
    end

    // final offset over the a vector, images numbered i*9 + j*3 + k
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int d = 0; d < NUM_DIMS; d++) begin
                        n_diff[i*9 + j*3 + k][d] =
                            f_sub_scaled(r_t[d][j][k], i_vec_a[d], 2'(i));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0   <= n_d0;
            r_t    <= n_t;
            r_diff <= n_diff;
        end
    end

    assign o_valid = r_v3;
    assign o_diff  = r_diff;

endmodule

>>> hdl/pmid_sq.sv
module pmid_sq import pmid_pkg::*; #(
    parameter int COORD_BITS = 21,
    localparam int DIFF_BITS = COORD_BITS + 3,
    localparam int SQ_BITS   = 2 * COORD_BITS + 4,
    localparam int SUM_BITS  = 2 * COORD_BITS + 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [DIFF_BITS-1:0] i_diff [NUM_IMG][NUM_DIMS],
    output logic                        o_valid,
    output logic [SUM_BITS-1:0]         o_sum  [NUM_IMG]
);

    logic                  r_v4, r_v5;
    logic [SQ_BITS-1:0]    r_sq  [NUM_IMG][NUM_DIMS];
    logic [SQ_BITS-1:0]    n_sq  [NUM_IMG][NUM_DIMS];
    logic [SUM_BITS-1:0]   r_sum [NUM_IMG];
    logic [SUM_BITS-1:0]   n_sum [NUM_IMG];

    // one squarer per image and axis; |diff| < 5 * 2^(COORD_BITS-1)
    always_comb begin
        logic signed [2*DIFF_BITS-1:0] prod;
        prod = '0;
        for (int n = 0; n < NUM_IMG; n++) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                prod = i_diff[n][d] * i_diff[n][d];
                n_sq[n][d] = SQ_BITS'($unsigned(prod));
            end
        end
    end

    always_comb begin
        for (int n = 0; n < NUM_IMG; n++) begin
            n_sum[n] = SUM_BITS'(r_sq[n][0]) + SUM_BITS'(r_sq[n][1])
                     + SUM_BITS'(r_sq[n][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq  <= n_sq;
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_v5;
    assign o_sum   = r_sum;

endmodule

>>> hdl/pmid_min.sv
module pmid_min import pmid_pkg::*; #(
    parameter int COORD_BITS = 21,
    localparam int SUM_BITS  = 2 * COORD_BITS + 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SUM_BITS-1:0] i_sum [NUM_IMG],
    output logic                o_valid,
    output logic [SUM_BITS-1:0] o_min
);

    function automatic logic [SUM_BITS-1:0] f_min3(
        input logic [SUM_BITS-1:0] a,
        input logic [SUM_BITS-1:0] b,
        input logic [SUM_BITS-1:0] c
    );
        logic [SUM_BITS-1:0] m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

    logic                r_v6, r_v7, r_v8;
    logic [SUM_BITS-1:0] r_m9 [9];
    logic [SUM_BITS-1:0] n_m9 [9];
    logic [SUM_BITS-1:0] r_m3 [3];
    logic [SUM_BITS-1:0] n_m3 [3];
    logic [SUM_BITS-1:0] r_min;
    logic [SUM_BITS-1:0] n_min;

    // 27 -> 9 -> 3 -> 1, one level per stage
    always_comb begin
        for (int g = 0; g < 9; g++) begin
            n_m9[g] = f_min3(i_sum[3*g], i_sum[3*g + 1], i_sum[3*g + 2]);
        end
        for (int g = 0; g < 3; g++) begin
            n_m3[g] = f_min3(r_m9[3*g], r_m9[3*g + 1], r_m9[3*g + 2]);
        end
        n_min = f_min3(r_m3[0], r_m3[1], r_m3[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (i_en) begin
            r_v6 <= i_valid;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m9  <= n_m9;
            r_m3  <= n_m3;
            r_min <= n_min;
        end
    end

    assign o_valid = r_v8;
    assign o_min   = r_min;

    a_min_not_above_groups: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_v7) |=> (r_min <= $past(r_m3[0])) && (r_min <= $past(r_m3[1]))
                           && (r_min <= $past(r_m3[2])))
        else $error("min stage result above one of its group minima");

    a_min_is_a_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_v7) |=> (r_min == $past(r_m3[0])) || (r_min == $past(r_m3[1]))
                           || (r_min == $past(r_m3[2])))
        else $error("min stage result matches none of its inputs");

endmodule

>>> hdl/periodic_min_image_dist2.sv
// minimum-image squared distance, 3d, 27 periodic images
//
// input stream (s_axis): one point and one atom position per transfer, six signed
// coordinates with 10 fraction bits. output stream (m_axis): the smallest squared
// distance from the point to atom + i*a + j*b + k*c, i, j, k in {-1, 0, 1}, unsigned
// with 20 fraction bits, exact and never saturated.
// config (apb): lattice vectors a, b, c at byte addresses 0x00, 0x08, 0x10, each
// three signed coordinates packed from bit 0 (x lowest); write only while idle.
//
// throughput: one transfer per cycle while m_axis_tready does not stall the
// pipeline. every image and axis has its own squarer, so the 27 images are
// evaluated in parallel in an eight-stage pipeline: three stages of offset adds,
// one of squares, one of per-image sums and three of min-of-three compares.
// a result stalled by m_axis_tready freezes the whole pipeline; a one-entry
// input skid keeps s_axis_tready registered, so it drops in the cycle after
// an item is taken during a stall, and that item waits in the skid.
// reset (synchronous, active low) empties the pipeline and the skid and clears
// all three lattice vectors to zero.
module periodic_min_image_dist2 import pmid_pkg::*; #(
    parameter int COORD_BITS = 21,
    localparam int IN_TDATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // point_x, point_y, point_z, atom_x, atom_y, atom_z from bit 0, zero padded
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,

    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // min_dist_sq from bit 0, zero padded
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_BITS-1:0]  paddr,
    input  logic [CFG_DATA_BITS-1:0]  pwdata,
    output logic [CFG_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    localparam int VEC_BITS  = NUM_DIMS * COORD_BITS;
    localparam int DIFF_BITS = COORD_BITS + 3;
    localparam int SUM_BITS  = 2 * COORD_BITS + 5;

    // lattice vector registers
    logic [VEC_BITS-1:0]   r_vec_a, r_vec_b, r_vec_c;
    t_reg_idx              w_reg_idx;
    logic                  w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[CFG_ADDR_BITS-1 -: 2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_a <= '0;
            r_vec_b <= '0;
            r_vec_c <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_VEC_A: r_vec_a <= pwdata[VEC_BITS-1:0];
                REG_VEC_B: r_vec_b <= pwdata[VEC_BITS-1:0];
                REG_VEC_C: r_vec_c <= pwdata[VEC_BITS-1:0];
                default:   ; // no register here, write dropped
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_VEC_A: prdata = CFG_DATA_BITS'(r_vec_a);
            REG_VEC_B: prdata = CFG_DATA_BITS'(r_vec_b);
            REG_VEC_C: prdata = CFG_DATA_BITS'(r_vec_c);
            default:   prdata = '0;
        endcase
    end

    // whole pipeline moves unless a finished result is held up
    logic w_en;
    logic w_out_valid;
    logic [SUM_BITS-1:0] w_min;

    assign w_en = !w_out_valid || m_axis_tready;

    // input skid: catches the one transfer taken while the pipeline is frozen
    logic                     r_skid_valid;
    logic                     n_skid_valid;
    logic [IN_TDATA_BITS-1:0] r_skid_data;
    logic                     w_accept;
    logic                     w_front_valid;
    logic [IN_TDATA_BITS-1:0] w_front_data;

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_front_valid = r_skid_valid || w_accept;
    assign w_front_data  = r_skid_valid ? r_skid_data : s_axis_tdata;
    assign n_skid_valid  = w_en ? 1'b0 : w_front_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else begin
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_accept) begin
            r_skid_data <= s_axis_tdata;
        end
    end

    // unpack coordinates
    logic signed [COORD_BITS-1:0] w_point [NUM_DIMS];
    logic signed [COORD_BITS-1:0] w_atom  [NUM_DIMS];
    logic signed [COORD_BITS-1:0] w_vec_a [NUM_DIMS];
    logic signed [COORD_BITS-1:0] w_vec_b [NUM_DIMS];
    logic signed [COORD_BITS-1:0] w_vec_c [NUM_DIMS];

    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            w_point[d] = w_front_data[d*COORD_BITS +: COORD_BITS];
            w_atom[d]  = w_front_data[(NUM_DIMS + d)*COORD_BITS +: COORD_BITS];
            w_vec_a[d] = r_vec_a[d*COORD_BITS +: COORD_BITS];
            w_vec_b[d] = r_vec_b[d*COORD_BITS +: COORD_BITS];
            w_vec_c[d] = r_vec_c[d*COORD_BITS +: COORD_BITS];
        end
    end

    // stages 1-3: per-image coordinate differences
    logic                        w_diff_valid;
    logic signed [DIFF_BITS-1:0] w_diff [NUM_IMG][NUM_DIMS];

    pmid_diff #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_valid),
        .i_point (w_point),
        .i_atom  (w_atom),
        .i_vec_a (w_vec_a),
        .i_vec_b (w_vec_b),
        .i_vec_c (w_vec_c),
        .o_valid (w_diff_valid),
        .o_diff  (w_diff)
    );

    // stages 4-5: squares and per-image sums
    logic                w_sum_valid;
    logic [SUM_BITS-1:0] w_sum [NUM_IMG];

    pmid_sq #(
        .COORD_BITS (COORD_BITS)
    ) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_diff_valid),
        .i_diff  (w_diff),
        .o_valid (w_sum_valid),
        .o_sum   (w_sum)
    );

    // stages 6-8: minimum tree, last stage is the output register
    pmid_min #(
        .COORD_BITS (COORD_BITS)
    ) u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sum_valid),
        .i_sum   (w_sum),
        .o_valid (w_out_valid),
        .o_min   (w_min)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'(w_min);

    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_en) |=> r_skid_valid)
        else $error("transfer taken during a stall was not held in the skid");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_en) |=> !r_skid_valid)
        else $error("skid entry not released when the pipeline moved");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_en) |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid entry lost during a stall");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pmid_pkg::*;

    // coordinate field width and packing of one point/atom pair
    localparam int COORD      = 21;
    localparam int PAIR_BITS  = 6 * COORD;
    localparam int IN_BITS    = ((PAIR_BITS + 7) / 8) * 8;
    localparam int PIPE_LAT   = 8;
    localparam int HOLD_AT    = 380;
    localparam int HOLD_LEN   = 300;
    localparam int REG_UNUSED = NUM_REGS;

    localparam logic [COORD-1:0] C_MIN  = 21'h100000;
    localparam logic [COORD-1:0] C_MAX  = 21'h0FFFFF;
    localparam logic [COORD-1:0] C_ZERO = 21'h000000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input stream
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // point_x, point_y, point_z, atom_x, atom_y, atom_z from bit 0, zero padded
    logic [IN_BITS-1:0]        s_axis_tdata  = '0;

    // output stream
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // min_dist_sq from bit 0, zero padded
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    // configuration port
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  paddr   = '0;
    logic [CFG_DATA_BITS-1:0]  pwdata  = '0;
    logic [CFG_DATA_BITS-1:0]  prdata;
    logic                      pready;

    periodic_min_image_dist2 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // pairs waiting to be sent, and distances waiting to come back
    logic [PAIR_BITS-1:0] pending_pairs [$];
    logic [OUT_BITS-1:0]  expected_dist [$];

    // local copy of the three lattice vectors (63 bits, top register bit dropped)
    logic [3*COORD-1:0]   lat_vec [NUM_REGS] = '{default: '0};

    logic burst_mode = 1'b0;    // no idling on either side while set
    int   pairs_in   = 0;       // input transfers so far
    int   dists_out  = 0;       // output transfers checked
    int   mismatches = 0;
    int   leftover   = 0;
    int   settings   = 1;       // lattice settings run (reset value counts)
    int   hold_left  = 0;
    logic hold_done  = 1'b0;
    logic [OUT_BITS-1:0] want_dist;

    // signed coordinate idx of a packed word, widened to 64 bits
    function automatic longint field_at(input logic [PAIR_BITS-1:0] w, input int idx);
        return longint'($signed(w[idx*COORD +: COORD]));
    endfunction

    // smallest squared distance from the point to the 27 periodic atom images
    function automatic logic [OUT_BITS-1:0] min_image_dist2(input logic [PAIR_BITS-1:0] pair);
        longint pt[3], at[3], va[3], vb[3], vc[3];
        longint diff, sum, best;
        for (int d = 0; d < 3; d++) begin
            pt[d] = field_at(pair, d);
            at[d] = field_at(pair, 3 + d);
            va[d] = field_at({63'b0, lat_vec[0]}, d);
            vb[d] = field_at({63'b0, lat_vec[1]}, d);
            vc[d] = field_at({63'b0, lat_vec[2]}, d);
        end
        best = -1;
        for (int i = -1; i <= 1; i++)
            for (int j = -1; j <= 1; j++)
                for (int k = -1; k <= 1; k++) begin
                    sum = 0;
                    for (int d = 0; d < 3; d++) begin
                        diff = pt[d] - (at[d] + i * va[d] + j * vb[d] + k * vc[d]);
                        sum  = sum + diff * diff;
                    end
                    // ties change nothing, only the minimum value matters
                    if (best < 0 || sum < best)
                        best = sum;
                end
        return best[OUT_BITS-1:0];
    endfunction

    function automatic logic [PAIR_BITS-1:0] make_pair(
        input logic [COORD-1:0] px, input logic [COORD-1:0] py, input logic [COORD-1:0] pz,
        input logic [COORD-1:0] ax, input logic [COORD-1:0] ay, input logic [COORD-1:0] az);
        return {az, ay, ax, pz, py, px};
    endfunction

    // append one pair to the sender's queue
    function automatic void add_pair(input logic [PAIR_BITS-1:0] pair);
        pending_pairs = {pending_pairs, pair};
    endfunction

    // span 0: extremes or full-range values; else mostly within +-span
    function automatic logic [COORD-1:0] rand_coord(input int span);
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return C_MIN;
        if (pick == 1) return C_MAX;
        if (pick == 2) return C_ZERO;
        if (span > 0 && pick < 12) return COORD'($urandom_range(0, 2 * span) - span);
        return COORD'($urandom);
    endfunction

    function automatic logic [PAIR_BITS-1:0] rand_pair(input int span);
        logic [PAIR_BITS-1:0] w;
        for (int d = 0; d < 6; d++)
            w[d*COORD +: COORD] = rand_coord(span);
        return w;
    endfunction

    // top register bit set at random, the block must ignore it
    function automatic logic [CFG_DATA_BITS-1:0] pack_vec(
        input logic [COORD-1:0] x, input logic [COORD-1:0] y, input logic [COORD-1:0] z);
        return {1'($urandom), z, y, x};
    endfunction

    // -------------------------------------------------------------------
    // sender: takes the next pair when the slot is free, idles ~25% of
    // cycles unless in burst mode
    // -------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_pairs.size() != 0 && (burst_mode || $urandom_range(0, 99) >= 25)) begin
                s_axis_tdata  <= {{(IN_BITS - PAIR_BITS){1'b0}}, pending_pairs.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off once enough pairs
    // went in, so the pipeline and the skid fill and s_axis backs up
    // -------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && pairs_in >= HOLD_AT) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_LEN;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= burst_mode || ($urandom_range(0, 99) >= 25);
        end
    end

    // -------------------------------------------------------------------
    // scoreboard: predict on every input transfer, check every output
    // transfer against the oldest prediction
    // -------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_dist = {expected_dist,
                                 min_image_dist2(s_axis_tdata[PAIR_BITS-1:0])};
                pairs_in <= pairs_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                dists_out++;
                if (expected_dist.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result min_dist_sq=%0d", $realtime,
                                 m_axis_tdata[OUT_BITS-1:0]);
                    mismatches++;
                end else begin
                    want_dist = expected_dist.pop_front();
                    if (m_axis_tdata[OUT_BITS-1:0] !== want_dist) begin
                        if (mismatches < 10)
                            $display("%0t: min_dist_sq mismatch, expected %0d got %0d",
                                     $realtime, want_dist, m_axis_tdata[OUT_BITS-1:0]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // apb write: setup cycle, then access cycle; the register takes it at
    // the edge where psel and penable are both high
    task automatic apb_write(input int idx, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'(idx * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // out-of-range index is dropped by the block
        if (idx < NUM_REGS)
            lat_vec[idx] = value[3*COORD-1:0];
    endtask

    task automatic set_lattice(input logic [CFG_DATA_BITS-1:0] a,
                               input logic [CFG_DATA_BITS-1:0] b,
                               input logic [CFG_DATA_BITS-1:0] c);
        apb_write(REG_VEC_A, a);
        apb_write(REG_VEC_B, b);
        apb_write(REG_VEC_C, c);
        settings++;
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pairs.size() != 0 || s_axis_tvalid || expected_dist.size() != 0);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
    endtask

    task automatic queue_random(input int count, input int span);
        repeat (count) add_pair(rand_pair(span));
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] rand_vec(input int span);
        return pack_vec(rand_coord(span), rand_coord(span), rand_coord(span));
    endfunction

    // -------------------------------------------------------------------
    // stimulus and end of run
    // -------------------------------------------------------------------
    initial begin
        int box;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero lattice after reset: plain squared distance
        add_pair(make_pair(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO));
        add_pair(make_pair(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
        add_pair(make_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        add_pair(make_pair(C_MAX, C_ZERO, C_MIN, C_MIN, C_ZERO, C_MAX));
        add_pair(make_pair(21'd5, -21'sd7, 21'd1234, 21'd5, -21'sd7, 21'd1234));
        wait_idle();

        // extreme lattice vectors; the unused address must change nothing
        set_lattice(pack_vec(C_MAX, C_MAX, C_MAX), pack_vec(C_MIN, C_MIN, C_MIN),
                    pack_vec(C_MAX, C_ZERO, C_MIN));
        apb_write(REG_UNUSED, {$urandom, $urandom});
        add_pair(make_pair(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
        add_pair(make_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        add_pair(make_pair(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO));
        add_pair(make_pair(C_MIN, C_MAX, C_ZERO, C_MAX, C_MIN, C_ZERO));
        queue_random(3, 0);
        wait_idle();

        // cubic box of side 2.0: equal-distance images around the midpoints
        set_lattice(pack_vec(21'd2048, C_ZERO, C_ZERO), pack_vec(C_ZERO, 21'd2048, C_ZERO),
                    pack_vec(C_ZERO, C_ZERO, 21'd2048));
        add_pair(make_pair(21'd1024, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO));
        add_pair(make_pair(21'd1024, 21'd1024, 21'd1024, C_ZERO, C_ZERO, C_ZERO));
        add_pair(make_pair(-21'sd1024, 21'd1024, -21'sd1024, C_ZERO, C_ZERO, C_ZERO));
        add_pair(make_pair(21'd3000, -21'sd3000, 21'd5000,
                           -21'sd100, 21'd100, -21'sd4000));
        add_pair(make_pair(21'd2047, 21'd1, C_ZERO, C_ZERO, 21'd2047, C_ZERO));
        wait_idle();

        // random, full-range lattice and coordinates
        set_lattice(rand_vec(0), rand_vec(0), rand_vec(0));
        queue_random(140, 0);
        wait_idle();

        // cubic box of random size, both sides running without idling
        box = $urandom_range(1024, 16384);
        set_lattice(pack_vec(COORD'(box), C_ZERO, C_ZERO), pack_vec(C_ZERO, COORD'(box), C_ZERO),
                    pack_vec(C_ZERO, C_ZERO, COORD'(box)));
        burst_mode <= 1'b1;
        queue_random(140, box);
        wait_idle();
        burst_mode <= 1'b0;

        // small skewed lattice; the long receiver hold-off lands here
        set_lattice(rand_vec(4096), rand_vec(4096), rand_vec(4096));
        queue_random(160, 8192);
        wait_idle();

        // medium lattice, sender pauses halfway until everything is back
        set_lattice(rand_vec(65536), rand_vec(65536), rand_vec(65536));
        queue_random(70, 131072);
        wait_idle();
        queue_random(70, 131072);
        wait_idle();

        // lattice components only at the extremes
        set_lattice(pack_vec($urandom_range(0, 1) ? C_MIN : C_MAX,
                             $urandom_range(0, 1) ? C_MIN : C_MAX,
                             $urandom_range(0, 1) ? C_MIN : C_MAX),
                    pack_vec($urandom_range(0, 1) ? C_MIN : C_MAX,
                             $urandom_range(0, 1) ? C_MIN : C_MAX,
                             $urandom_range(0, 1) ? C_MIN : C_MAX),
                    pack_vec($urandom_range(0, 1) ? C_MIN : C_MAX,
                             $urandom_range(0, 1) ? C_MIN : C_MAX,
                             $urandom_range(0, 1) ? C_MIN : C_MAX));
        queue_random(120, 0);

        // drain: all pairs sent, then a bounded wait for the last results
        do @(negedge i_clk);
        while (pending_pairs.size() != 0 || s_axis_tvalid);
        for (int n = 0; n < 4000 && expected_dist.size() != 0; n++)
            @(negedge i_clk);
        repeat (2 * PIPE_LAT) @(negedge i_clk);
        leftover = expected_dist.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);

        $display("covered %0d point/atom transfers over %0d lattice settings,", pairs_in,
                 settings);
        $display("  %0d distances checked, %0d mismatches", dists_out, mismatches);
        if (mismatches == 0 && leftover == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/pmid_pkg.sv
hdl/pmid_diff.sv
hdl/pmid_sq.sv
hdl/pmid_min.sv
hdl/periodic_min_image_dist2.sv
verif/tb.sv
